/* hdl/edwe_pkg.sv */
// ----------------------------------------------------------------------------
// edwe_pkg: shared types and constants of the EUC dense wide character encoder
// Holds the code-set constants, the register index codes and the descriptor
// that passes from the classifying front end to the byte sequencer.
// ----------------------------------------------------------------------------
package edwe_pkg;

  // Widths of the character and register paths.
  localparam int CODE_W        = 32;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int LEN_W         = 3;

  // Encoding constants.
  localparam int MAX_SET_BYTES = 4;
  localparam int GROUP_BITS    = 7;
  localparam int MAX_ITEMS     = MAX_SET_BYTES + 1;
  localparam int IDX_W         = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W         = $clog2(MAX_ITEMS + 1);
  localparam int GIDX_W        = (MAX_SET_BYTES > 1) ? $clog2(MAX_SET_BYTES) : 1;
  localparam int VAL_EXT_W     = GROUP_BITS * MAX_SET_BYTES + CODE_W;

  localparam logic [7:0] C1_LAST   = 8'h9F;
  localparam logic [7:0] PFX_SET2  = 8'h8E;
  localparam logic [7:0] PFX_SET3  = 8'h8F;
  localparam logic [7:0] HIGH_MARK = 8'h80;

  // Depth of the queue between front end and sequencer.
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SINGLE_BYTE = 3'd0,
    REG_SET_LENGTHS = 3'd1,
    REG_SET3_BASE   = 3'd2,
    REG_SET1_BASE   = 3'd3,
    REG_DENSE_LAST  = 3'd4,
    REG_SET1_OFFSET = 3'd5,
    REG_SET2_OFFSET = 3'd6,
    REG_SET3_OFFSET = 3'd7
  } cfg_reg_t;

  // One classified character: the bytes to send, in order, and how many.
  typedef struct packed {
    logic                           illegal;
    logic [CNT_W-1:0]               count;
    logic [MAX_ITEMS-1:0][7:0]      bytes;
  } desc_t;

endpackage

/* hdl/euc_dense_wchar_encoder.sv */
// ----------------------------------------------------------------------------
// euc_dense_wchar_encoder: dense wide character to EUC byte sequence
// Encodes one 32-bit wide character per input beat into one to five result
// beats: an optional single-shift prefix and the 7-bit groups of the code.
//
//   channel   direction  handshake            payload
//   input     in         push / full          wide_code
//   result    out        empty / pop          out_byte, last_byte, illegal
//   config    in         cfg_we               cfg_index, cfg_data
//
// A character has one to five result beats, and the byte sequencer sends
// one beat per cycle while the result side keeps popping; single-byte codes
// and rejected characters, having a single beat, then run at one per cycle.
// An accepted character is written into the queue; its first beat moves into
// the result register once it is at the head and that register is free.
// A synchronous reset clears the configuration registers to zero and empties
// the queue and the result register.
// A stalled result side fills the two-entry queue before full rises, so the
// input keeps moving while a finished beat waits to be popped.
// ----------------------------------------------------------------------------
module euc_dense_wchar_encoder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [edwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [edwe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [edwe_pkg::CODE_W-1:0]       wide_code,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        out_byte,
  output logic                              last_byte,
  output logic                              illegal
);
  import edwe_pkg::*;

  // The front end classifies the incoming character combinationally and the
  // queue captures the finished descriptor at the accepting edge.
  desc_t front_desc;
  desc_t head_desc;
  logic  q_empty;
  logic  q_pop;

  edwe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wide_code (wide_code),
    .desc      (front_desc)
  );

  // A full queue is what the input side sees as full.
  edwe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_desc (front_desc),
    .q_full  (full),
    .rd_en   (q_pop),
    .rd_desc (head_desc),
    .q_empty (q_empty)
  );

  // The sequencer walks the head descriptor and retires it with its last beat.
  edwe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head_desc),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .illegal   (illegal)
  );

  // A rejected character is a lone zero beat that closes the character.
  a_illegal_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && illegal) |-> (last_byte && (out_byte == 8'h00)))
    else $error("illegal beat is not a lone zero byte");

  // The remaining beats of a character are still queued, so the result
  // register refills right after a non-final beat is taken.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_byte) |=> !empty)
    else $error("gap inside a character's byte sequence");

  // Inside a multibyte sequence the only C1 bytes are the single-shift
  // prefixes; a C1 code passed through on its own is a final beat.
  a_c1_prefix_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && !illegal && !last_byte && (out_byte[7:5] == 3'b100)) |->
      ((out_byte == PFX_SET2) || (out_byte == PFX_SET3)))
    else $error("C1 byte other than a prefix sent");

endmodule

/* hdl/edwe_front.sv */
// ----------------------------------------------------------------------------
// edwe_front: configuration registers and character classifier
// Selects the code set, subtracts its offset, checks every group for a C1
// byte and lays out the finished byte list for the sequencer.
// ----------------------------------------------------------------------------
module edwe_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [edwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [edwe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [edwe_pkg::CODE_W-1:0]       wide_code,
  output edwe_pkg::desc_t                   desc
);
  import edwe_pkg::*;

  logic              single_byte_locale;
  logic [8:0]        set_byte_lengths;
  logic [CODE_W-1:0] set3_base;
  logic [CODE_W-1:0] set1_base;
  logic [CODE_W-1:0] dense_last;
  logic [CODE_W-1:0] set1_offset;
  logic [CODE_W-1:0] set2_offset;
  logic [CODE_W-1:0] set3_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      single_byte_locale <= 1'b0;
      set_byte_lengths   <= '0;
      set3_base          <= '0;
      set1_base          <= '0;
      dense_last         <= '0;
      set1_offset        <= '0;
      set2_offset        <= '0;
      set3_offset        <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SINGLE_BYTE: single_byte_locale <= cfg_data[0];
        REG_SET_LENGTHS: set_byte_lengths   <= cfg_data[8:0];
        REG_SET3_BASE:   set3_base          <= cfg_data;
        REG_SET1_BASE:   set1_base          <= cfg_data;
        REG_DENSE_LAST:  dense_last         <= cfg_data;
        REG_SET1_OFFSET: set1_offset        <= cfg_data;
        REG_SET2_OFFSET: set2_offset        <= cfg_data;
        REG_SET3_OFFSET: set3_offset        <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0]  len1, len2, len3;
  logic              hit1, hit2, hit3;
  logic [CODE_W-1:0] diff1, diff2, diff3;

  // The three compares and subtracts run side by side; selection follows.
  assign len1  = set_byte_lengths[2:0];
  assign len2  = set_byte_lengths[5:3];
  assign len3  = set_byte_lengths[8:6];
  assign hit2  = (len2 != '0) && (wide_code < set3_base);
  assign hit3  = (len3 != '0) && (wide_code < set1_base);
  assign hit1  = (len1 != '0) && (wide_code <= dense_last);
  assign diff1 = wide_code - set1_offset;
  assign diff2 = wide_code - set2_offset;
  assign diff3 = wide_code - set3_offset;

  logic [CODE_W-1:0]           value;
  logic [VAL_EXT_W-1:0]        value_ext;
  logic [LEN_W-1:0]            len;
  logic                        has_pfx;
  logic [7:0]                  pfx;
  logic                        no_set;
  logic                        bad_group;
  logic [MAX_SET_BYTES-1:0][GROUP_BITS-1:0] grp;
  logic [LEN_W-1:0]            gsel;

  always_comb begin
    value   = diff1;
    len     = len1;
    has_pfx = 1'b0;
    pfx     = PFX_SET2;
    no_set  = 1'b0;
    if (hit2) begin
      value   = diff2;
      len     = len2;
      has_pfx = 1'b1;
      pfx     = PFX_SET2;
    end else if (hit3) begin
      value   = diff3;
      len     = len3;
      has_pfx = 1'b1;
      pfx     = PFX_SET3;
    end else if (!hit1) begin
      no_set  = 1'b1;
    end
  end

  assign value_ext = VAL_EXT_W'(value);

  always_comb begin
    bad_group = 1'b0;
    for (int k = 0; k < MAX_SET_BYTES; k++) begin
      grp[k] = value_ext[GROUP_BITS*k +: GROUP_BITS];
      // A group whose top two bits are clear becomes a C1 byte.
      if ((k < int'(len)) && (grp[k][GROUP_BITS-1 -: 2] == 2'b00)) begin
        bad_group = 1'b1;
      end
    end
  end

  always_comb begin
    desc = '0;
    gsel = '0;
    if (wide_code <= CODE_W'(C1_LAST)) begin
      desc.count    = CNT_W'(1);
      desc.bytes[0] = wide_code[7:0];
    end else if (wide_code[CODE_W-1:8] == '0) begin
      // High Latin-1 only passes through in a single-byte locale.
      desc.count = CNT_W'(1);
      if (single_byte_locale) begin
        desc.bytes[0] = wide_code[7:0];
      end else begin
        desc.illegal = 1'b1;
      end
    end else if (no_set || (int'(len) > MAX_SET_BYTES) || bad_group) begin
      desc.count   = CNT_W'(1);
      desc.illegal = 1'b1;
    end else begin
      desc.count = CNT_W'(len) + CNT_W'(has_pfx);
      if (has_pfx) begin
        desc.bytes[0] = pfx;
      end
      // Most significant group goes first.
      for (int j = 0; j < MAX_SET_BYTES; j++) begin
        if (j < int'(len)) begin
          gsel = len - LEN_W'(j + 1);
          if (has_pfx) begin
            desc.bytes[j+1] = HIGH_MARK | 8'(grp[gsel[GIDX_W-1:0]]);
          end else begin
            desc.bytes[j] = HIGH_MARK | 8'(grp[gsel[GIDX_W-1:0]]);
          end
        end
      end
    end
  end

endmodule

/* hdl/edwe_queue.sv */
// ----------------------------------------------------------------------------
// edwe_queue: short descriptor queue
// A small flip-flop FIFO that lets the front end and the sequencer stall
// independently of each other.
// ----------------------------------------------------------------------------
module edwe_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  edwe_pkg::desc_t  wr_desc,
  output logic             q_full,
  input  logic             rd_en,
  output edwe_pkg::desc_t  rd_desc,
  output logic             q_empty
);
  import edwe_pkg::*;

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_wr, do_rd;

  assign q_full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_desc = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/edwe_back.sv */
// ----------------------------------------------------------------------------
// edwe_back: byte sequencer and output register
// Walks the head descriptor one byte per cycle into a result register while
// that register is free, and retires the descriptor with its final byte.
// ----------------------------------------------------------------------------
module edwe_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  edwe_pkg::desc_t  head,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic             last_byte,
  output logic             illegal
);
  import edwe_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             advance;
  logic             head_last;

  assign empty     = !out_valid;
  assign advance   = !q_empty && (!out_valid || pop);
  assign head_last = ((CNT_W'(idx) + CNT_W'(1)) == head.count);
  assign q_pop     = advance && head_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        idx       <= head_last ? '0 : idx + IDX_W'(1);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= head.bytes[idx];
      last_byte <= head_last;
      illegal   <= head.illegal;
    end
  end

endmodule

/* bench/euc_dense_wchar_encoder_check.sv */
// ----------------------------------------------------------------------------
// euc_dense_wchar_encoder_check: result checker for the EUC encoder bench
// Watches the configuration port and both queue channels, works out the byte
// sequence of every accepted wide character and compares each popped result
// beat with the oldest expected beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module euc_dense_wchar_encoder_check (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [edwe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [edwe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              push,
  input  logic                              full,
  input  logic [edwe_pkg::CODE_W-1:0]       wide_code,
  input  logic                              empty,
  input  logic                              pop,
  input  logic [7:0]                        out_byte,
  input  logic                              last_byte,
  input  logic                              illegal,
  output int                                errors,
  output int                                outstanding
);
  import edwe_pkg::*;

  localparam int LATIN1_END = 256;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       is_last;
    logic       is_illegal;
  } enc_beat_t;

  // Mirror of the block's registers, updated from the write port.
  logic               locale_single;
  logic [8:0]         set_lengths;
  logic [CODE_W-1:0]  set3_start;
  logic [CODE_W-1:0]  set1_start;
  logic [CODE_W-1:0]  set1_last;
  logic [CODE_W-1:0]  set1_sub;
  logic [CODE_W-1:0]  set2_sub;
  logic [CODE_W-1:0]  set3_sub;

  enc_beat_t pending_bytes[$];
  int        beats_seen;

  // Appends the result beats of one wide character to pending_bytes.
  function automatic void encode_wide_char(input logic [CODE_W-1:0] code);
    int                len;
    logic [CODE_W-1:0] value;
    logic [7:0]        prefix;
    logic [7:0]        grp [MAX_SET_BYTES];
    logic [7:0]        b;
    bit                has_prefix;
    bit                bad;
    if (code <= CODE_W'(C1_LAST) ||
        (code < CODE_W'(LATIN1_END) && locale_single)) begin
      pending_bytes.push_back('{code_byte: code[7:0], is_last: 1'b1, is_illegal: 1'b0});
      return;
    end
    bad = (code < CODE_W'(LATIN1_END));
    has_prefix = 1'b0;
    prefix = 8'h00;
    value = '0;
    len = 0;
    if (!bad) begin
      if (set_lengths[5:3] != 0 && code < set3_start) begin
        has_prefix = 1'b1;
        prefix = PFX_SET2;
        value = code - set2_sub;
        len = int'(set_lengths[5:3]);
      end else if (set_lengths[8:6] != 0 && code < set1_start) begin
        has_prefix = 1'b1;
        prefix = PFX_SET3;
        value = code - set3_sub;
        len = int'(set_lengths[8:6]);
      end else if (set_lengths[2:0] != 0 && code <= set1_last) begin
        value = code - set1_sub;
        len = int'(set_lengths[2:0]);
      end else begin
        bad = 1'b1;
      end
    end
    if (len > MAX_SET_BYTES) bad = 1'b1;
    if (!bad) begin
      for (int i = len; i > 0; i--) begin
        b = value[7:0] | HIGH_MARK;
        if (b <= C1_LAST) bad = 1'b1;
        grp[i-1] = b;
        value = value >> GROUP_BITS;
      end
    end
    if (bad) begin
      pending_bytes.push_back('{code_byte: 8'h00, is_last: 1'b1, is_illegal: 1'b1});
      return;
    end
    if (has_prefix)
      pending_bytes.push_back('{code_byte: prefix, is_last: 1'b0, is_illegal: 1'b0});
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{code_byte: grp[i], is_last: (i == len - 1), is_illegal: 1'b0});
  endfunction

  always @(posedge clk) begin : watch
    enc_beat_t want;
    if (rst) begin
      locale_single = 1'b0;
      set_lengths = '0;
      set3_start = '0;
      set1_start = '0;
      set1_last = '0;
      set1_sub = '0;
      set2_sub = '0;
      set3_sub = '0;
      pending_bytes.delete();
      errors = 0;
      beats_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SINGLE_BYTE: locale_single = cfg_data[0];
          REG_SET_LENGTHS: set_lengths = cfg_data[8:0];
          REG_SET3_BASE:   set3_start = cfg_data;
          REG_SET1_BASE:   set1_start = cfg_data;
          REG_DENSE_LAST:  set1_last = cfg_data;
          REG_SET1_OFFSET: set1_sub = cfg_data;
          REG_SET2_OFFSET: set2_sub = cfg_data;
          REG_SET3_OFFSET: set3_sub = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) encode_wide_char(wide_code);
      if (pop && !empty) begin
        beats_seen++;
        if (pending_bytes.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result beat %0d with nothing expected:", $realtime, beats_seen,
                     " byte %02h last %0d illegal %0d", out_byte, last_byte, illegal);
        end else begin
          want = pending_bytes.pop_front();
          if (want.code_byte !== out_byte || want.is_last !== last_byte ||
              want.is_illegal !== illegal) begin
            errors++;
            if (errors <= 10)
              $display("%0t: result beat %0d: expected byte %02h last %0d illegal %0d,",
                       $realtime, beats_seen, want.code_byte, want.is_last,
                       want.is_illegal,
                       " got byte %02h last %0d illegal %0d",
                       out_byte, last_byte, illegal);
          end
        end
      end
    end
    outstanding = pending_bytes.size();
  end

endmodule

/* bench/euc_dense_wchar_encoder_test.sv */
// ----------------------------------------------------------------------------
// euc_dense_wchar_encoder_test: top level of the EUC encoder bench
// Runs the encoder through a series of register settings: the reset values,
// a typical three-set layout, extreme bases and offsets, oversized and
// zero-length sets, and random layouts. Each setting gets directed
// characters, random ones or both, while both channels idle at random.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module euc_dense_wchar_encoder_test;
  import edwe_pkg::*;

  // Worst case is about five beats per character, each waiting out a long
  // result stall, so this bound is many times the slowest correct run.
  localparam int LIMIT = 500000;

  // The register settings of one test phase, in register index order.
  typedef struct {
    logic              single;
    logic [8:0]        lengths;
    logic [CODE_W-1:0] set3_start;
    logic [CODE_W-1:0] set1_start;
    logic [CODE_W-1:0] set1_last;
    logic [CODE_W-1:0] set1_sub;
    logic [CODE_W-1:0] set2_sub;
    logic [CODE_W-1:0] set3_sub;
  } enc_setup_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   push;
  logic                   full;
  logic [CODE_W-1:0]      wide_code;
  logic                   empty;
  logic                   pop;
  logic [7:0]             out_byte;
  logic                   last_byte;
  logic                   illegal;

  int         errors;
  int         outstanding;
  int         cycles = 0;
  bit         quiet = 1'b0;  // when set, neither side starts a new idle gap
  enc_setup_t setup;

  always #6 clk = ~clk;

  euc_dense_wchar_encoder uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .wide_code (wide_code),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .last_byte (last_byte),
    .illegal   (illegal)
  );

  euc_dense_wchar_encoder_check encoding_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .wide_code   (wide_code),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .last_byte   (last_byte),
    .illegal     (illegal),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("euc_dense_wchar_encoder: mismatch");
      $finish;
    end
  end

  // Idle lengths: half of them zero, most of the rest short, a few long.
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CODE_W-1:0] set_offset(int s);
    case (s)
      1:       return setup.set1_sub;
      2:       return setup.set2_sub;
      default: return setup.set3_sub;
    endcase
  endfunction

  // Builds a code in set s whose every 7-bit group has bit 6 or bit 5 set, so
  // no byte falls into the C1 range. Where the set length is unusable a
  // random group count is taken and the code is simply noise.
  function automatic logic [CODE_W-1:0] legal_code(int s);
    int                n;
    logic [CODE_W-1:0] value;
    logic [1:0]        top;
    logic [4:0]        rest;
    n = int'(setup.lengths[3*(s-1) +: 3]);
    if (n == 0 || n > MAX_SET_BYTES) n = $urandom_range(1, MAX_SET_BYTES);
    value = '0;
    repeat (n) begin
      top = 2'($urandom_range(1, 3));
      rest = 5'($urandom_range(0, 31));
      value = (value << GROUP_BITS) | CODE_W'({top, rest});
    end
    return set_offset(s) + value;
  endfunction

  // Writes one register; called and returns at a falling edge.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setup();
    write_reg(REG_SINGLE_BYTE, CFG_DATA_W'(setup.single));
    write_reg(REG_SET_LENGTHS, CFG_DATA_W'(setup.lengths));
    write_reg(REG_SET3_BASE, setup.set3_start);
    write_reg(REG_SET1_BASE, setup.set1_start);
    write_reg(REG_DENSE_LAST, setup.set1_last);
    write_reg(REG_SET1_OFFSET, setup.set1_sub);
    write_reg(REG_SET2_OFFSET, setup.set2_sub);
    write_reg(REG_SET3_OFFSET, setup.set3_sub);
  endtask

  // Offers one character after a random gap and holds it until accepted.
  // The data lines carry junk while push is low.
  task automatic send_char(logic [CODE_W-1:0] code);
    int gap;
    gap = quiet ? 0 : pick_gap();
    repeat (gap) begin
      wide_code = $urandom();
      @(negedge clk);
    end
    push = 1'b1;
    wide_code = code;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    push = 1'b0;
  endtask

  // Registers may only change while the block is idle. Every character gives
  // at least one beat, so an empty expectation list means the block is idle;
  // a few more cycles cover the pipeline anyway.
  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random characters for the current setup. Most are well formed codes of
  // a random set; the rest are single-byte codes, set boundaries and noise.
  task automatic random_chars(int count);
    int                k;
    logic [CODE_W-1:0] code;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      if (k < 65) begin
        code = legal_code($urandom_range(1, 3));
      end else if (k < 75) begin
        code = CODE_W'($urandom_range(0, 255));
      end else if (k < 87) begin
        case ($urandom_range(0, 6))
          0:       code = setup.set3_start - 1;
          1:       code = setup.set3_start;
          2:       code = setup.set1_start - 1;
          3:       code = setup.set1_start;
          4:       code = setup.set1_last;
          5:       code = setup.set1_last + 1;
          default: code = set_offset($urandom_range(1, 3));
        endcase
      end else begin
        code = $urandom();
      end
      send_char(code);
    end
    quiet = 1'b0;
  endtask

  // Random layout: sets in ascending order above the single-byte range, with
  // offsets that match the set start half the time so that many codes encode.
  task automatic random_setup();
    setup.single = 1'($urandom_range(0, 1));
    setup.lengths = {3'($urandom_range(0, 5)), 3'($urandom_range(0, 5)),
                     3'($urandom_range(0, 5))};
    setup.set3_start = 32'h100 + $urandom_range(0, 32'h0010_0000);
    setup.set1_start = setup.set3_start + $urandom_range(0, 32'h0100_0000);
    setup.set1_last = setup.set1_start + $urandom_range(0, 32'h0100_0000);
    setup.set2_sub = $urandom_range(0, 1) ? 32'h100 : $urandom();
    setup.set3_sub = $urandom_range(0, 1) ? setup.set3_start : $urandom();
    setup.set1_sub = $urandom_range(0, 1) ? setup.set1_start : $urandom();
    apply_setup();
  endtask

  // The result side pops most of the time, with random stalls of random
  // length; during quiet stretches it starts no new stall.
  initial begin : result_drain
    int hold;
    hold = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop = 1'b0;
      end else if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else begin
        pop = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    push = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SINGLE_BYTE;
    cfg_data = '0;
    wide_code = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // All registers zero: no set has a length, so anything above the
    // single-byte range is rejected, and high Latin-1 is rejected too.
    setup = '{1'b0, 9'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
    apply_setup();
    send_char(32'h0000_0000);
    send_char(32'h0000_009F);
    send_char(32'h0000_00A0);
    send_char(32'h0000_0100);
    send_char(32'hFFFF_FFFF);
    drain();

    // Three-set layout: set 2 two bytes from 0x100, set 3 three bytes from
    // 0x4100, set 1 two bytes from 0x204100 up to 0x2080FF.
    setup = '{1'b0, 9'd210, 32'h0000_4100, 32'h0020_4100, 32'h0020_80FF,
              32'h0020_4100, 32'h0000_0100, 32'h0000_4100};
    apply_setup();
    send_char(32'h0000_00FF);  // high Latin-1 in a multibyte locale
    send_char(32'h0000_0100);  // set 2 value zero: C1 bytes
    send_char(32'h0000_40FF);  // last code of set 2
    send_char(32'h0000_4090);  // low group in the C1 range
    send_char(32'h0000_097F);  // high group in the C1 range
    send_char(32'h0000_4100);  // first code of set 3, C1 bytes
    send_char(32'h0020_40FF);  // last code of set 3
    send_char(32'h0020_80FF);  // last valid dense code, set 1
    send_char(32'h0020_8100);  // beyond every set
    random_chars(15);
    drain();

    // Single-byte locale, set 2 at the full four bytes, set 3 of zero length
    // and set 1 oversized, with the upper bases and offsets at their maximum.
    setup = '{1'b1, 9'd39, 32'h1000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    apply_setup();
    send_char(32'h0000_00A0);
    send_char(32'h0000_00FF);
    send_char(32'h0FFF_FFFF);  // prefix and four bytes, the longest result
    send_char(32'hFFFF_FFFF);  // falls in the oversized set 1
    random_chars(20);
    drain();

    // Only set 1, spanning the whole code space, with bases at zero and an
    // offset that makes the subtraction wrap.
    setup = '{1'b0, 9'd4, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h0000_0000, 32'h0000_0000};
    apply_setup();
    send_char(32'h7FFF_FFFF);
    send_char(32'hFFFF_FFFF);
    random_chars(15);
    drain();

    // Every set length at its maximum, so every multibyte set is oversized.
    setup = '{1'b1, 9'd511, $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom()};
    apply_setup();
    random_chars(8);
    drain();

    repeat (2) begin
      random_setup();
      random_chars(16);
      drain();
    end

    // Let any stray beat show up before the verdict.
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && outstanding == 0)
      $display("euc_dense_wchar_encoder: match");
    else
      $display("euc_dense_wchar_encoder: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hdl/edwe_pkg.sv
hdl/edwe_front.sv
hdl/edwe_queue.sv
hdl/edwe_back.sv
hdl/euc_dense_wchar_encoder.sv
bench/euc_dense_wchar_encoder_check.sv
bench/euc_dense_wchar_encoder_test.sv
